FILE: hw/rtl/rhva_pkg.sv
// Shared types and constants for the rectangle Hough vote accumulator.
// Used by rectangle_hough_vote_accumulator; no dependencies.
package rhva_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;
   localparam int SIZE_BITS      = 9;   // min size + index, up to 255 + 7 at default parameters
   localparam int COORD_BITS     = 12;  // signed candidate coordinates
   localparam int OUT_COUNT_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_ROWS = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_COLS = 2'd3;

   localparam logic OP_VOTE = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_PLANE,
      ST_RD_BASE,
      ST_RD_WAIT,
      ST_RD_DATA,
      ST_VERT,
      ST_HORZ,
      ST_DRAIN,
      ST_RESP
   } state_type;

endpackage

FILE: hw/rtl/rhva_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rhva_ram #(
   parameter int     WIDTH = 16,
   parameter longint DEPTH = 262144,
   localparam int    ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/rectangle_hough_vote_accumulator.sv
// Rectangle Hough vote accumulator top level; depends on rhva_pkg and rhva_ram.
// A vote with a zero pixel is answered without touching the RAM; other votes walk each plane's
//   vertical then horizontal sides, then drain the update pipeline before responding.
// Throughput: one transaction at a time; req_tready stays low until the response is loaded.
// Reset: control state cleared, then the vote RAM is zeroed at one cell per cycle
//   (262144 cells at defaults) with req_tready low.
module rectangle_hough_vote_accumulator #(
   parameter int NUM_WIDTHS  = 8,
   parameter int NUM_HEIGHTS = 8,
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // row[5:0], col[11:6], pixel[19:12], width_index[22:20], height_index[25:23]
   input  logic [31:0]                          req_tdata,
   // op
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // cell_count[15:0], saturated[16]
   output logic [23:0]                          rsp_tdata,
   input  logic                                 csr_we,
   input  logic [rhva_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rhva_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam longint CELLS     = longint'(MAX_ROWS) * longint'(MAX_COLS);
   localparam longint DEPTH     = longint'(NUM_WIDTHS) * longint'(NUM_HEIGHTS) * CELLS;
   localparam int     ADDR_BITS = $clog2(DEPTH);
   localparam int     RB        = $clog2(MAX_ROWS);
   localparam int     CB        = $clog2(MAX_COLS);
   localparam int     WB        = (NUM_WIDTHS > 1) ? $clog2(NUM_WIDTHS) : 1;
   localparam int     HB        = (NUM_HEIGHTS > 1) ? $clog2(NUM_HEIGHTS) : 1;
   localparam int     SB        = rhva_pkg::SIZE_BITS;
   localparam int     XB        = rhva_pkg::COORD_BITS;
   localparam int     OB        = rhva_pkg::OUT_COUNT_BITS;

   localparam logic [ADDR_BITS-1:0]  CELLS_A   = ADDR_BITS'(CELLS);
   localparam logic [ADDR_BITS-1:0]  COLS_A    = ADDR_BITS'(MAX_COLS);
   localparam logic [ADDR_BITS-1:0]  HEIGHTS_A = ADDR_BITS'(NUM_HEIGHTS);
   localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam logic [WB-1:0]         W_LAST    = WB'(NUM_WIDTHS - 1);
   localparam logic [HB-1:0]         H_LAST    = HB'(NUM_HEIGHTS - 1);
   localparam logic [XB-1:0]         ROWS_X    = XB'(MAX_ROWS);
   localparam logic [XB-1:0]         COLS_X    = XB'(MAX_COLS);
   localparam logic [COUNT_BITS-1:0] COUNT_CEIL = '1;

   // control
   rhva_pkg::state_type    state_ff, state_in;
   logic [7:0]             min_width_ff, min_width_in;
   logic [7:0]             min_height_ff, min_height_in;
   logic [6:0]             image_rows_ff, image_rows_in;
   logic [6:0]             image_cols_ff, image_cols_in;
   logic [WB-1:0]          w_ff, w_in;
   logic [HB-1:0]          h_ff, h_in;
   logic [SB-1:0]          k_ff, k_in;
   logic                   side_ff, side_in;
   logic [ADDR_BITS-1:0]   base_ff, base_in;
   logic [ADDR_BITS-1:0]   clear_cnt_ff, clear_cnt_in;
   logic                   p0_valid_ff, s1_valid_ff, fwd_valid_ff;
   logic                   overflow_ff, overflow_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload
   logic                   item_op_ff;
   logic [5:0]             item_row_ff, item_col_ff;
   logic [2:0]             item_wi_ff, item_hi_ff;
   logic [OB-1:0]          result_count_ff;
   logic [RB-1:0]          p0_r_ff;
   logic [CB-1:0]          p0_c_ff;
   logic [ADDR_BITS-1:0]   p0_base_ff;
   logic [ADDR_BITS-1:0]   s1_addr_ff;
   logic [ADDR_BITS-1:0]   fwd_addr_ff;
   logic [COUNT_BITS-1:0]  fwd_data_ff;
   logic [OB-1:0]          rsp_count_ff;
   logic                   rsp_sat_ff;

   // combinational
   logic                   req_accept;
   logic                   gen_valid;
   logic [RB-1:0]          gen_r;
   logic [CB-1:0]          gen_c;
   logic                   next_plane;
   logic                   rsp_load;
   logic [SB-1:0]          wid, hgt;
   logic signed [XB-1:0]   w2_s, h2_s, pr_s, pc_s, k_s, nr_s, nc_s;
   logic signed [XB-1:0]   c1_s, c2_s, r1_s, r2_s, vr_s, hc_s;
   logic                   col_ok, row_ok, vr_ok, hc_ok, rd_ok;
   logic [ADDR_BITS-1:0]   rd_plane;
   logic [ADDR_BITS-1:0]   addr_comb;
   logic [COUNT_BITS-1:0]  bump_old, bump_new;
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_waddr;
   logic [COUNT_BITS-1:0]  ram_wdata, ram_rdata;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == rhva_pkg::ST_IDLE);

   // candidate geometry for the current plane
   assign wid  = SB'(min_width_ff) + SB'(w_ff);
   assign hgt  = SB'(min_height_ff) + SB'(h_ff);
   assign w2_s = $signed(XB'(wid >> 1));
   assign h2_s = $signed(XB'(hgt >> 1));
   assign pr_s = $signed(XB'(item_row_ff));
   assign pc_s = $signed(XB'(item_col_ff));
   assign k_s  = $signed(XB'(k_ff));
   assign nr_s = $signed((XB'(image_rows_ff) > ROWS_X) ? ROWS_X : XB'(image_rows_ff));
   assign nc_s = $signed((XB'(image_cols_ff) > COLS_X) ? COLS_X : XB'(image_cols_ff));
   assign c1_s = pc_s - w2_s;
   assign c2_s = pc_s + w2_s;
   assign r1_s = pr_s - h2_s;
   assign r2_s = pr_s + h2_s;
   assign vr_s = pr_s + k_s - h2_s;
   assign hc_s = pc_s + k_s - w2_s;
   assign col_ok = (c1_s >= 0) && (c1_s < nc_s) && (c2_s >= 0) && (c2_s < nc_s);
   assign row_ok = (r1_s >= 0) && (r1_s < nr_s) && (r2_s >= 0) && (r2_s < nr_s);
   assign vr_ok  = (vr_s >= 0) && (vr_s < nr_s);
   assign hc_ok  = (hc_s >= 0) && (hc_s < nc_s);

   assign rd_ok = (32'(item_wi_ff) < NUM_WIDTHS) && (32'(item_hi_ff) < NUM_HEIGHTS)
                  && (32'(item_row_ff) < MAX_ROWS) && (32'(item_col_ff) < MAX_COLS);
   assign rd_plane = ADDR_BITS'(item_wi_ff) * HEIGHTS_A + ADDR_BITS'(item_hi_ff);

   // shared address unit and read-modify-write with one-deep forwarding
   assign addr_comb = p0_base_ff + ADDR_BITS'(p0_r_ff) * COLS_A + ADDR_BITS'(p0_c_ff);
   assign bump_old  = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rdata;
   assign bump_new  = (bump_old != COUNT_CEIL) ? bump_old + COUNT_BITS'(1) : bump_old;
   assign ram_we    = (state_ff == rhva_pkg::ST_CLEAR) || s1_valid_ff;
   assign ram_waddr = (state_ff == rhva_pkg::ST_CLEAR) ? clear_cnt_ff : s1_addr_ff;
   assign ram_wdata = (state_ff == rhva_pkg::ST_CLEAR) ? '0 : bump_new;
   assign overflow_in = overflow_ff || (s1_valid_ff && (bump_new == COUNT_CEIL));

   rhva_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_comb),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      min_width_in  = min_width_ff;
      min_height_in = min_height_ff;
      image_rows_in = image_rows_ff;
      image_cols_in = image_cols_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      k_in          = k_ff;
      side_in       = side_ff;
      base_in       = base_ff;
      clear_cnt_in  = clear_cnt_ff;
      gen_valid     = 1'b0;
      gen_r         = '0;
      gen_c         = '0;
      next_plane    = 1'b0;
      rsp_load      = 1'b0;

      if (csr_we) begin
         case (csr_index)
            rhva_pkg::CSR_MIN_WIDTH:  min_width_in  = csr_wdata;
            rhva_pkg::CSR_MIN_HEIGHT: min_height_in = csr_wdata;
            rhva_pkg::CSR_IMAGE_ROWS: image_rows_in = csr_wdata[6:0];
            rhva_pkg::CSR_IMAGE_COLS: image_cols_in = csr_wdata[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         rhva_pkg::ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + ADDR_BITS'(1);
            if (clear_cnt_ff == LAST_ADDR) begin
               state_in = rhva_pkg::ST_IDLE;
            end
         end
         rhva_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == rhva_pkg::OP_READ) begin
                  state_in = rhva_pkg::ST_RD_PLANE;
               end else if (req_tdata[19:12] != 8'd0) begin
                  state_in = rhva_pkg::ST_VERT;
                  w_in     = '0;
                  h_in     = '0;
                  k_in     = '0;
                  side_in  = 1'b0;
                  base_in  = '0;
               end else begin
                  state_in = rhva_pkg::ST_RESP;
               end
            end
         end
         rhva_pkg::ST_RD_PLANE: begin
            base_in  = rd_plane;
            state_in = rhva_pkg::ST_RD_BASE;
         end
         rhva_pkg::ST_RD_BASE: begin
            state_in = rhva_pkg::ST_RD_WAIT;
         end
         rhva_pkg::ST_RD_WAIT: begin
            state_in = rhva_pkg::ST_RD_DATA;
         end
         rhva_pkg::ST_RD_DATA: begin
            state_in = rhva_pkg::ST_RESP;
         end
         rhva_pkg::ST_VERT: begin
            if (!col_ok) begin
               state_in = rhva_pkg::ST_HORZ;
               k_in     = '0;
               side_in  = 1'b0;
            end else begin
               if (vr_ok) begin
                  gen_valid = 1'b1;
                  gen_r     = RB'($unsigned(vr_s));
                  gen_c     = side_ff ? CB'($unsigned(c2_s)) : CB'($unsigned(c1_s));
               end
               if (vr_ok && !side_ff) begin
                  side_in = 1'b1;
               end else begin
                  side_in = 1'b0;
                  if (k_ff == hgt) begin
                     state_in = rhva_pkg::ST_HORZ;
                     k_in     = '0;
                  end else begin
                     k_in = k_ff + SB'(1);
                  end
               end
            end
         end
         rhva_pkg::ST_HORZ: begin
            if (!row_ok) begin
               next_plane = 1'b1;
            end else begin
               if (hc_ok) begin
                  gen_valid = 1'b1;
                  gen_r     = side_ff ? RB'($unsigned(r2_s)) : RB'($unsigned(r1_s));
                  gen_c     = CB'($unsigned(hc_s));
               end
               if (hc_ok && !side_ff) begin
                  side_in = 1'b1;
               end else begin
                  side_in = 1'b0;
                  if (k_ff == wid) begin
                     next_plane = 1'b1;
                  end else begin
                     k_in = k_ff + SB'(1);
                  end
               end
            end
         end
         rhva_pkg::ST_DRAIN: begin
            if (!p0_valid_ff && !s1_valid_ff) begin
               state_in = rhva_pkg::ST_RESP;
            end
         end
         rhva_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = rhva_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rhva_pkg::ST_IDLE;
         end
      endcase

      if (next_plane) begin
         k_in    = '0;
         side_in = 1'b0;
         base_in = base_ff + CELLS_A;
         if (h_ff == H_LAST) begin
            h_in = '0;
            if (w_ff == W_LAST) begin
               state_in = rhva_pkg::ST_DRAIN;
            end else begin
               w_in     = w_ff + WB'(1);
               state_in = rhva_pkg::ST_VERT;
            end
         end else begin
            h_in     = h_ff + HB'(1);
            state_in = rhva_pkg::ST_VERT;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rhva_pkg::ST_CLEAR;
         min_width_ff  <= 8'd5;
         min_height_ff <= 8'd5;
         image_rows_ff <= 7'd64;
         image_cols_ff <= 7'd64;
         w_ff          <= '0;
         h_ff          <= '0;
         k_ff          <= '0;
         side_ff       <= 1'b0;
         base_ff       <= '0;
         clear_cnt_ff  <= '0;
         p0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_width_ff  <= min_width_in;
         min_height_ff <= min_height_in;
         image_rows_ff <= image_rows_in;
         image_cols_ff <= image_cols_in;
         w_ff          <= w_in;
         h_ff          <= h_in;
         k_ff          <= k_in;
         side_ff       <= side_in;
         base_ff       <= base_in;
         clear_cnt_ff  <= clear_cnt_in;
         p0_valid_ff   <= gen_valid;
         s1_valid_ff   <= p0_valid_ff;
         fwd_valid_ff  <= s1_valid_ff;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_op_ff      <= req_tuser;
         item_row_ff     <= req_tdata[5:0];
         item_col_ff     <= req_tdata[11:6];
         item_wi_ff      <= req_tdata[22:20];
         item_hi_ff      <= req_tdata[25:23];
         result_count_ff <= '0;
      end else if (state_ff == rhva_pkg::ST_RD_DATA) begin
         result_count_ff <= (rd_ok && (item_op_ff == rhva_pkg::OP_READ)) ? OB'(ram_rdata) : '0;
      end
      if (gen_valid) begin
         p0_r_ff    <= gen_r;
         p0_c_ff    <= gen_c;
         p0_base_ff <= base_ff;
      end else if (state_ff == rhva_pkg::ST_RD_BASE) begin
         p0_r_ff    <= RB'(item_row_ff);
         p0_c_ff    <= CB'(item_col_ff);
         p0_base_ff <= base_ff * CELLS_A;
      end
      s1_addr_ff  <= addr_comb;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= bump_new;
      if (rsp_load) begin
         rsp_count_ff <= result_count_ff;
         rsp_sat_ff   <= overflow_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_sat_ff, rsp_count_ff};

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rhva_pkg::ST_IDLE) |-> (!p0_valid_ff && !s1_valid_ff))
      else $error("vote pipeline not drained in idle");

   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(overflow_ff)) |-> overflow_ff)
      else $error("saturated flag dropped");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == rhva_pkg::ST_RESP))
      else $error("response raised outside response state");

   a_write_in_vote: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == rhva_pkg::ST_VERT || state_ff == rhva_pkg::ST_HORZ
                       || state_ff == rhva_pkg::ST_DRAIN))
      else $error("counter update outside vote transaction");

endmodule
